>>> hw/rtl/can_dl_pkg.sv
// Shared types and constants for the CAN download packet reassembler.
package can_dl_pkg;

    localparam int ID_W          = 29;
    localparam int ADDR_W        = 19;
    localparam int PAYLOAD_BYTES = 6;
    localparam int IDX_W         = $clog2(PAYLOAD_BYTES);
    localparam int QUEUE_DEPTH   = 2;
    localparam int PADDR_W       = 3;
    localparam int PDATA_W       = 32;

    localparam logic [ID_W-1:0]  BASE_ID       = 29'h500;
    localparam logic [ID_W-1:0]  NODE_ID_RESET = 29'hFF;
    localparam logic [IDX_W-1:0] LAST_IDX      = IDX_W'(PAYLOAD_BYTES - 1);
    localparam logic [15:0]      COUNT_MAX     = 16'hFFFF;

    // Register index (paddr word bit)
    localparam logic REG_NODE_ID = 1'b0;

    // Result kinds
    localparam logic KIND_HEADER = 1'b0;
    localparam logic KIND_WRITE  = 1'b1;

    typedef struct packed {
        logic [ID_W-1:0] frame_id;
        logic [7:0]      byte0;
        logic [7:0]      byte1;
        logic [7:0]      byte2;
        logic [7:0]      byte3;
        logic [7:0]      byte4;
        logic [7:0]      byte5;
        logic [7:0]      byte6;
        logic [7:0]      byte7;
    } in_item_t;

    typedef struct packed {
        logic              kind;
        logic [ADDR_W-1:0] write_address;
        logic [7:0]        write_byte;
        logic [15:0]       package_count;
        logic [15:0]       total_length;
        logic [15:0]       expected_crc;
        logic [15:0]       byte_count;
        logic              finished;
        logic              last;
    } out_item_t;

    // Classified frame handed from front to back
    typedef struct packed {
        logic                                is_header;
        logic [ADDR_W-1:0]                   base_address;
        logic [PAYLOAD_BYTES-1:0][7:0]       payload;
    } frame_cmd_t;

    typedef struct packed {
        logic       valid;
        frame_cmd_t cmd;
    } enq_req_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

>>> hw/rtl/can_dl_front.sv
// Front end: accepts frames, filters identifiers and classifies packets.
module can_dl_front
    import can_dl_pkg::*;
(
    input  logic            push,
    output logic            full,
    input  in_item_t        frame,
    input  logic [ID_W-1:0] node_id,
    input  q_status_t       q_status,
    output enq_req_t        enq
);

    logic        accept;
    logic        id_hit;
    logic [15:0] pkt;
    logic [15:0] pkt_m1;
    logic [ADDR_W-1:0] pkt_ext;

    assign full   = q_status.full;
    assign accept = push && !q_status.full;

    // Download identifier match, broadcast or node-specific
    assign id_hit = (frame.frame_id == BASE_ID) || (frame.frame_id == (BASE_ID | node_id));

    // Packet number and base buffer address (packet-1)*6
    assign pkt     = {frame.byte1, frame.byte0};
    assign pkt_m1  = pkt - 16'd1;
    assign pkt_ext = ADDR_W'(pkt_m1);

    always_comb
    begin
        enq.valid            = accept && id_hit;
        enq.cmd.is_header    = (pkt == 16'd0);
        enq.cmd.base_address = (pkt_ext << 2) + (pkt_ext << 1);
        enq.cmd.payload      = {frame.byte7, frame.byte6, frame.byte5,
                                frame.byte4, frame.byte3, frame.byte2};
    end

endmodule

>>> hw/rtl/can_dl_queue.sv
// Short queue of classified frames between front and back.
module can_dl_queue
    import can_dl_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  enq_req_t   enq,
    input  logic       deq,
    output frame_cmd_t deq_cmd,
    output q_status_t  status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    frame_cmd_t         mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               do_wr, do_rd;

    assign status.full  = (cnt_reg == CNT_W'(DEPTH));
    assign status.empty = (cnt_reg == '0);
    assign do_wr        = enq.valid && !status.full;
    assign do_rd        = deq && !status.empty;
    assign deq_cmd      = mem_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= enq.cmd;
        end
    end

endmodule

>>> hw/rtl/can_dl_back.sv
// Back end: latches headers, emits byte writes and keeps the byte count.
module can_dl_back
    import can_dl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  q_status_t  q_status,
    input  frame_cmd_t q_cmd,
    output logic       q_pop,
    output out_item_t  result,
    output logic       empty,
    input  logic       pop
);

    frame_cmd_t       cmd_reg, cmd_next;
    logic             busy_reg, busy_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    out_item_t        out_reg, out_next;
    logic             out_valid_reg, out_valid_next;
    logic [15:0]      pc_reg, pc_next;
    logic [15:0]      len_reg, len_next;
    logic [15:0]      crc_reg, crc_next;
    logic [15:0]      cnt_reg, cnt_next;
    logic             done_reg, done_next;

    logic        take, step, fin, hit;
    logic [15:0] cnt_inc;

    assign take   = pop && out_valid_reg;
    assign step   = busy_reg && (!out_valid_reg || pop);
    assign empty  = !out_valid_reg;
    assign result = out_reg;

    assign cnt_inc = (cnt_reg == COUNT_MAX) ? cnt_reg : cnt_reg + 16'd1;
    assign hit     = (cnt_inc == len_reg);

    // One result per step; next frame loads as the current one ends
    always_comb
    begin
        cmd_next       = cmd_reg;
        busy_next      = busy_reg;
        idx_next       = idx_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !take;
        pc_next        = pc_reg;
        len_next       = len_reg;
        crc_next       = crc_reg;
        cnt_next       = cnt_reg;
        done_next      = done_reg;
        fin            = 1'b0;

        if (step)
        begin
            out_valid_next = 1'b1;
            if (cmd_reg.is_header)
            begin
                pc_next                = {cmd_reg.payload[1], cmd_reg.payload[0]};
                len_next               = {cmd_reg.payload[3], cmd_reg.payload[2]};
                crc_next               = {cmd_reg.payload[5], cmd_reg.payload[4]};
                out_next.kind          = KIND_HEADER;
                out_next.write_address = '0;
                out_next.write_byte    = '0;
                out_next.package_count = pc_next;
                out_next.total_length  = len_next;
                out_next.expected_crc  = crc_next;
                out_next.byte_count    = cnt_reg;
                out_next.finished      = done_reg;
                out_next.last          = 1'b1;
                fin                    = 1'b1;
            end
            else
            begin
                cnt_next               = cnt_inc;
                done_next              = done_reg || hit;
                out_next.kind          = KIND_WRITE;
                out_next.write_address = cmd_reg.base_address + ADDR_W'(idx_reg);
                out_next.write_byte    = cmd_reg.payload[idx_reg];
                out_next.package_count = pc_reg;
                out_next.total_length  = len_reg;
                out_next.expected_crc  = crc_reg;
                out_next.byte_count    = cnt_inc;
                out_next.finished      = done_next;
                out_next.last          = hit || (idx_reg == LAST_IDX);
                fin                    = out_next.last;
                idx_next               = idx_reg + 1'b1;
            end
        end

        if (fin)
        begin
            busy_next = 1'b0;
            idx_next  = '0;
        end

        q_pop = (!busy_reg || fin) && !q_status.empty;
        if (q_pop)
        begin
            cmd_next  = q_cmd;
            busy_next = 1'b1;
            idx_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            pc_reg        <= '0;
            len_reg       <= '0;
            crc_reg       <= '0;
            cnt_reg       <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            pc_reg        <= pc_next;
            len_reg       <= len_next;
            crc_reg       <= crc_next;
            cnt_reg       <= cnt_next;
            done_reg      <= done_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        out_reg <= out_next;
    end

    // Byte count only grows
    a_cnt_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> cnt_reg >= $past(cnt_reg))
        else $error("byte count decreased");

    // Finished flag is sticky
    a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> done_reg)
        else $error("finished flag cleared");

    // Byte index stays inside the payload while a frame is active
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> idx_reg <= LAST_IDX)
        else $error("byte index out of range");

    // A header result always closes its frame
    a_header_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_reg.kind == KIND_HEADER)) |-> out_reg.last)
        else $error("header result without last");

    // No frame is pulled from the queue while the current one is mid-way
    a_no_early_load: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !step) |-> !q_pop)
        else $error("frame loaded while busy");

endmodule

>>> hw/rtl/can_download_packet_reassembler.sv
// Top level of the CAN download packet reassembler.
//
//  channel  | handshake              | payload      | notes
//  ---------+------------------------+--------------+------------------------------
//  frame    | push / full            | in_item_t    | taken when push && !full
//  result   | empty / pop            | out_item_t   | taken when pop && !empty
//  config   | psel/penable/pwrite    | pwdata[28:0] | node_id at 0x0, pready tied 1
//
// A header frame gives one result; a data frame gives one to six results,
// set by the back-end byte sequencer, one per cycle unless pop stalls the result.
// Frames with a foreign identifier are absorbed in the accept cycle.
// The frame queue (QUEUE_DEPTH entries) lets the front keep accepting while
// the result register is stalled by pop; full rises once it fills.
// Reset clears all latched header values, the byte count and the flag.
module can_download_packet_reassembler
    import can_dl_pkg::*;
#(
    parameter int QUEUE_DEPTH = can_dl_pkg::QUEUE_DEPTH
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  in_item_t           frame,
    output logic               empty,
    input  logic               pop,
    output out_item_t          result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic [ID_W-1:0] node_id_reg, node_id_next;
    q_status_t       q_status;
    enq_req_t        enq;
    frame_cmd_t      q_cmd;
    logic            q_pop;
    logic            reg_sel;

    // Configuration register
    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == REG_NODE_ID);
    assign prdata  = reg_sel ? PDATA_W'(node_id_reg) : '0;

    always_comb
    begin
        node_id_next = node_id_reg;
        if (psel && penable && pwrite && pready && reg_sel)
        begin
            node_id_next = pwdata[ID_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_id_reg <= NODE_ID_RESET;
        end
        else
        begin
            node_id_reg <= node_id_next;
        end
    end

    can_dl_front u_front (
        .push     (push),
        .full     (full),
        .frame    (frame),
        .node_id  (node_id_reg),
        .q_status (q_status),
        .enq      (enq)
    );

    can_dl_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .enq     (enq),
        .deq     (q_pop),
        .deq_cmd (q_cmd),
        .status  (q_status)
    );

    can_dl_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_status (q_status),
        .q_cmd    (q_cmd),
        .q_pop    (q_pop),
        .result   (result),
        .empty    (empty),
        .pop      (pop)
    );

endmodule
